// ===== hdl/dual_lane_spi_psram_access_assert.svh =====
// Assertion macros for the dual-lane SPI PSRAM access master.
`ifndef DUAL_LANE_SPI_PSRAM_ACCESS_ASSERT_SVH
`define DUAL_LANE_SPI_PSRAM_ACCESS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DLSPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlspa assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DLSPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlspa assertion failed");

`endif

// ===== hdl/dlspa_pkg.sv =====
// Types and constants of the dual-lane SPI PSRAM access master.
package dlspa_pkg;

   // Input field widths
   localparam int unsigned FUNC_W    = 2;
   localparam int unsigned ADDR_W    = 24;
   localparam int unsigned WCOUNT_W  = 12;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned FRAME_W   = 32;
   localparam int unsigned BITCNT_W  = 5;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // SPI command bytes
   localparam logic [7:0] CMD_WRITE     = 8'h02;
   localparam logic [7:0] CMD_FAST_READ = 8'h0B;

   // Bit counts of the frame phases
   localparam logic [BITCNT_W-1:0] CMD_LAST_BIT  = 5'd31;
   localparam logic [BITCNT_W-1:0] BYTE_LAST_BIT = 5'd7;

   // Access phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_CMD   = 4'b0010,
      PH_DUMMY = 4'b0100,
      PH_DATA  = 4'b1000
   } phase_type;

   // One result transaction
   typedef struct packed {
      logic              cs_n;
      logic              sck_pulse;
      logic              mosi_low;
      logic              mosi_high;
      logic              word_taken;
      logic [WORD_W-1:0] read_word;
      logic              read_valid;
      logic              busy_res;
      logic              last;
   } rsp_payload_type;

endpackage

// ===== hdl/dlspa_channels.sv =====
// Valid/ready channel interfaces for requests and results.
interface dlspa_req_if
   import dlspa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [ADDR_W-1:0]   address;
   logic [WCOUNT_W-1:0] word_count;
   logic [WORD_W-1:0]   write_word;
   logic                miso_low;
   logic                miso_high;

   modport source (output valid, func, address, word_count, write_word, miso_low,
                   miso_high, input ready);
   modport sink   (input valid, func, address, word_count, write_word, miso_low,
                   miso_high, output ready);
endinterface

interface dlspa_rsp_if
   import dlspa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              cs_n;
   logic              sck_pulse;
   logic              mosi_low;
   logic              mosi_high;
   logic              word_taken;
   logic [WORD_W-1:0] read_word;
   logic              read_valid;
   logic              busy_res;
   logic              last;

   modport source (output valid, cs_n, sck_pulse, mosi_low, mosi_high, word_taken,
                   read_word, read_valid, busy_res, last, input ready);
   modport sink   (input valid, cs_n, sck_pulse, mosi_low, mosi_high, word_taken,
                   read_word, read_valid, busy_res, last, output ready);
endinterface

// ===== hdl/dual_lane_spi_psram_access.sv =====
// Dual-lane SPI PSRAM access master, one SPI bit time per transaction.
// A result transaction is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the result register frees when taken.
// An access lasts 32 ticks of command and address, 8 dummy ticks on a read, 8 per word.
// Reset is synchronous, active high: phase goes idle and the result register empties.
`include "dual_lane_spi_psram_access_assert.svh"

module dual_lane_spi_psram_access
   import dlspa_pkg::*;
#(
   parameter int unsigned MAX_WORDS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   dlspa_req_if.sink   req_ch,
   dlspa_rsp_if.source rsp_ch
);

   localparam int unsigned WL_W = $clog2(MAX_WORDS + 1);

   // Access state
   phase_type            phase_ff, phase_in;
   logic [BITCNT_W-1:0]  bit_counter_ff, bit_counter_in;
   logic [WL_W-1:0]      words_left_ff, words_left_in;
   logic                 is_write_ff, is_write_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [WORD_W-1:0]    tx_word_ff, tx_word_in;
   logic [WORD_W-1:0]    rx_word_ff, rx_word_in;

   // Result register
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_ff, rsp_in;

   logic                 req_acc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // Next state and result of one bit tick
   always_comb begin
      phase_type           ph_e;
      logic [BITCNT_W-1:0] bc_e;
      logic [WL_W-1:0]     wl_e;
      logic [WL_W-1:0]     wl_dec;
      logic                wr_e;
      logic [FRAME_W-1:0]  fr_e;
      logic [WORD_W-1:0]   tx_e;
      logic [WORD_W-1:0]   rx_e;
      logic [2:0]          j;

      ph_e = phase_ff;
      bc_e = bit_counter_ff;
      wl_e = words_left_ff;
      wr_e = is_write_ff;
      fr_e = frame_ff;
      tx_e = tx_word_ff;
      rx_e = rx_word_ff;

      // start only when idle; zero words means one, large counts saturate
      if (phase_ff == PH_IDLE && (req_ch.func == FUNC_WRITE || req_ch.func == FUNC_READ)) begin
         wr_e = (req_ch.func == FUNC_WRITE);
         if (req_ch.word_count == '0) begin
            wl_e = WL_W'(1);
         end else if (32'(req_ch.word_count) > 32'(MAX_WORDS)) begin
            wl_e = WL_W'(MAX_WORDS);
         end else begin
            wl_e = WL_W'(req_ch.word_count);
         end
         fr_e = {(wr_e ? CMD_WRITE : CMD_FAST_READ), req_ch.address};
         bc_e = '0;
         tx_e = '0;
         rx_e = '0;
         ph_e = PH_CMD;
      end

      phase_in       = ph_e;
      bit_counter_in = bc_e;
      words_left_in  = wl_e;
      is_write_in    = wr_e;
      frame_in       = fr_e;
      tx_word_in     = tx_e;
      rx_word_in     = rx_e;

      rsp_in      = '0;
      rsp_in.cs_n = 1'b1;

      j      = ~bc_e[2:0];
      wl_dec = (wl_e != '0) ? wl_e - WL_W'(1) : wl_e;

      unique case (ph_e)
         PH_IDLE: begin
         end
         PH_CMD: begin
            rsp_in.cs_n      = 1'b0;
            rsp_in.busy_res  = 1'b1;
            rsp_in.sck_pulse = 1'b1;
            rsp_in.mosi_low  = fr_e[FRAME_W-1];
            rsp_in.mosi_high = fr_e[FRAME_W-1];
            frame_in         = fr_e << 1;
            bit_counter_in   = bc_e + BITCNT_W'(1);
            if (bc_e == CMD_LAST_BIT) begin
               bit_counter_in = '0;
               phase_in       = wr_e ? PH_DATA : PH_DUMMY;
            end
         end
         PH_DUMMY: begin
            rsp_in.cs_n      = 1'b0;
            rsp_in.busy_res  = 1'b1;
            rsp_in.sck_pulse = 1'b1;
            bit_counter_in   = bc_e + BITCNT_W'(1);
            if (bc_e == BYTE_LAST_BIT) begin
               bit_counter_in = '0;
               phase_in       = PH_DATA;
            end
         end
         PH_DATA: begin
            rsp_in.cs_n      = 1'b0;
            rsp_in.busy_res  = 1'b1;
            rsp_in.sck_pulse = 1'b1;
            if (wr_e) begin
               // latch the write word on the first bit of each word
               if (bc_e == '0) begin
                  tx_word_in        = req_ch.write_word;
                  rsp_in.word_taken = 1'b1;
               end
               rsp_in.mosi_low  = tx_word_in[{1'b0, j}];
               rsp_in.mosi_high = tx_word_in[{1'b1, j}];
            end else begin
               rx_word_in = {rx_e[14:8], req_ch.miso_high, rx_e[6:0], req_ch.miso_low};
            end
            bit_counter_in = bc_e + BITCNT_W'(1);
            if (bc_e == BYTE_LAST_BIT) begin
               bit_counter_in = '0;
               if (!wr_e) begin
                  rsp_in.read_valid = 1'b1;
                  rsp_in.read_word  = rx_word_in;
               end
               words_left_in = wl_dec;
               if (wl_dec == '0) begin
                  rsp_in.last = 1'b1;
                  phase_in    = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // State registers, updated on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_counter_ff <= '0;
         words_left_ff  <= '0;
         is_write_ff    <= 1'b0;
         frame_ff       <= '0;
         tx_word_ff     <= '0;
         rx_word_ff     <= '0;
      end else if (req_acc) begin
         phase_ff       <= phase_in;
         bit_counter_ff <= bit_counter_in;
         words_left_ff  <= words_left_in;
         is_write_ff    <= is_write_in;
         frame_ff       <= frame_in;
         tx_word_ff     <= tx_word_in;
         rx_word_ff     <= rx_word_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cs_n       = rsp_ff.cs_n;
   assign rsp_ch.sck_pulse  = rsp_ff.sck_pulse;
   assign rsp_ch.mosi_low   = rsp_ff.mosi_low;
   assign rsp_ch.mosi_high  = rsp_ff.mosi_high;
   assign rsp_ch.word_taken = rsp_ff.word_taken;
   assign rsp_ch.read_word  = rsp_ff.read_word;
   assign rsp_ch.read_valid = rsp_ff.read_valid;
   assign rsp_ch.busy_res   = rsp_ff.busy_res;
   assign rsp_ch.last       = rsp_ff.last;

   // Checks
   `DLSPA_ASSERT_NOW(a_idle_counter_clear, clock, reset, phase_ff == PH_IDLE, bit_counter_ff == '0)
   `DLSPA_ASSERT_NOW(a_dummy_only_on_read, clock, reset, phase_ff == PH_DUMMY, !is_write_ff)
   `DLSPA_ASSERT_NEXT(a_last_goes_idle, clock, reset, req_acc && rsp_in.last, phase_ff == PH_IDLE)
   `DLSPA_ASSERT_NOW(a_no_take_on_read, clock, reset, rsp_valid_ff && rsp_ff.read_valid, !rsp_ff.word_taken && !rsp_ff.cs_n == rsp_ff.busy_res)

endmodule
